// ===== design/dss_pkg.sv =====
package dss_pkg;

  localparam int IN_TRACK_W = 16;
  localparam int TOT_W      = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TOT_W-1:0] TOTAL_MAX = 24'hFFFFFF;

  // policy codes
  localparam logic [1:0] MODE_FIFO  = 2'd0;
  localparam logic [1:0] MODE_SSTF  = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;
  localparam logic [1:0] MODE_CSCAN = 2'd3;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_POLICY = 1'b0;
  localparam logic CFG_IDX_DIR    = 1'b1;

  typedef struct packed {
    logic [IN_TRACK_W-1:0] track;
    logic                  last_request;
  } in_word_t;

  typedef struct packed {
    logic [IN_TRACK_W-1:0] served_track;
    logic [TOT_W-1:0]      seek_sum;
    logic                  last_served;
  } out_word_t;

  typedef struct packed {
    logic [1:0] policy_mode;
    logic       initial_direction;
  } cfg_t;

endpackage

// ===== design/disk_seek_scheduler_unit.sv =====
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------------
// input     | start, busy, in_word           | word taken when start && !busy
// result    | out_valid, out_word            | word shown for one cycle, no stall
// config    | psel, penable, pwrite, paddr,  | APB write on access phase,
//           | pwdata, prdata, pready         | pready tied high
//
// Loading takes one track per cycle. Once the set closes (last_request, or the
// store is full) the start track is emitted via state S_FIRST and the result
// register. Each further SSTF, SCAN or C-SCAN track takes one pass of reads
// over the stored requests after the start track, a wait state for the RAM
// read register and a decide state; a reversal or wrap adds one more pass.
// FIFO reads only the next entry. Reset is synchronous, active low, and needs
// no RAM clearing. Results cannot be stalled; busy drops with the final track.
module disk_seek_scheduler_unit
  import dss_pkg::*;
#(
  parameter int MAX_SEQUENCE = 64,
  parameter int TRACK_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(MAX_SEQUENCE);
  localparam int CNT_W = $clog2(MAX_SEQUENCE + 1);
  localparam int SUM_W = ((TRACK_BITS > TOT_W) ? TRACK_BITS : TOT_W) + 1;
  localparam int ENT_W = TRACK_BITS + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  cfg_t cfg;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [TRACK_BITS-1:0] head_r, head_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;
  logic                  dir_r, dir_nxt;
  logic                  wrap_r, wrap_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]      end_idx_r, end_idx_nxt;
  logic                  pv_r, pv_nxt;
  logic [IDX_W-1:0]      pidx_r, pidx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [TRACK_BITS-1:0] best_trk_r, best_trk_nxt;
  logic [TRACK_BITS-1:0] best_d_r, best_d_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [ENT_W-1:0]      mem_rdata;

  logic [TRACK_BITS-1:0] trk_in;
  logic [TRACK_BITS-1:0] rd_trk;
  logic                  rd_srv;
  logic [TRACK_BITS-1:0] rd_dist;
  logic                  dir_ok;
  logic                  cand_ok;
  logic                  trigger;
  logic [CNT_W-1:0]      n_m1;
  logic [CNT_W-1:0]      k_inc;
  logic                  scan_go;
  logic [CNT_W-1:0]      scan_k;

  logic [TOT_W-1:0]      add_base;
  logic [TRACK_BITS-1:0] add_opnd;
  logic [SUM_W-1:0]      sum_w;
  logic [TOT_W-1:0]      add_res;
  logic [SUM_W-1:0]      diff_w;
  logic [TOT_W-1:0]      sub_res;
  logic [TRACK_BITS-1:0] emit_trk;
  logic [IN_TRACK_W-1:0] emit_trk16;

  dss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // entry = {served mark, track}
  dss_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SEQUENCE)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_r),
    .rdata (mem_rdata)
  );

  generate
    if (TRACK_BITS <= IN_TRACK_W) begin : g_narrow
      assign trk_in = in_word.track[TRACK_BITS-1:0];
    end else begin : g_wide
      assign trk_in = {{(TRACK_BITS-IN_TRACK_W){1'b0}}, in_word.track};
    end
    if (TRACK_BITS >= IN_TRACK_W) begin : g_out_cut
      assign emit_trk16 = emit_trk[IN_TRACK_W-1:0];
    end else begin : g_out_ext
      assign emit_trk16 = {{(IN_TRACK_W-TRACK_BITS){1'b0}}, emit_trk};
    end
  endgenerate

  assign rd_trk  = mem_rdata[TRACK_BITS-1:0];
  assign rd_srv  = mem_rdata[TRACK_BITS];
  assign rd_dist = (rd_trk > head_r) ? (rd_trk - head_r) : (head_r - rd_trk);
  assign dir_ok  = (rd_trk == head_r) || (dir_r && (rd_trk > head_r)) ||
                   (!dir_r && (rd_trk < head_r));

  always_comb begin
    case (mode_r)
      MODE_FIFO:  cand_ok = 1'b1;
      MODE_SSTF:  cand_ok = !rd_srv && (!found_r || (rd_dist <= best_d_r));
      MODE_SCAN:  cand_ok = !rd_srv && dir_ok && (!found_r || (rd_dist <= best_d_r));
      MODE_CSCAN: cand_ok = !rd_srv && (rd_trk >= head_r) &&
                            (!found_r || (rd_dist < best_d_r));
      default:    cand_ok = 1'b0;
    endcase
  end

  assign trigger = in_word.last_request || (cnt_r == CNT_W'(MAX_SEQUENCE - 1));
  assign n_m1    = n_r - CNT_W'(1);
  assign k_inc   = k_r + CNT_W'(1);

  // shared saturating adder and floor-at-zero subtractor for the total
  assign sum_w   = SUM_W'(add_base) + SUM_W'(add_opnd);
  assign add_res = (sum_w > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_w[TOT_W-1:0];
  assign diff_w  = SUM_W'(total_r) - SUM_W'(best_trk_r);
  assign sub_res = (total_r == TOTAL_MAX) ? TOTAL_MAX :
                   ((SUM_W'(best_trk_r) >= SUM_W'(total_r)) ? '0 : diff_w[TOT_W-1:0]);

  assign emit_trk = (state_r == S_DECIDE) ? best_trk_r : head_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    dir_nxt       = dir_r;
    wrap_nxt      = wrap_r;
    mode_nxt      = mode_r;
    rd_idx_nxt    = rd_idx_r;
    end_idx_nxt   = end_idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = rd_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_trk_nxt  = best_trk_r;
    best_d_nxt    = best_d_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = best_idx_r;
    mem_wdata     = {1'b1, best_trk_r};
    add_base      = '0;
    add_opnd      = head_r;
    scan_go       = 1'b0;
    scan_k        = k_r;

    // fold the word read last cycle into the running best
    if (pv_r && cand_ok) begin
      found_nxt    = 1'b1;
      best_idx_nxt = pidx_r;
      best_trk_nxt = rd_trk;
      best_d_nxt   = rd_dist;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[IDX_W-1:0];
          mem_wdata = {1'b0, trk_in};
          if (cnt_r == '0) begin
            head_nxt = trk_in;
          end
          if (trigger) begin
            n_nxt     = cnt_r + CNT_W'(1);
            cnt_nxt   = '0;
            mode_nxt  = cfg.policy_mode;
            dir_nxt   = cfg.initial_direction;
            state_nxt = S_FIRST;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_FIRST: begin
        add_base                  = '0;
        add_opnd                  = head_r;
        total_nxt                 = add_res;
        wrap_nxt                  = 1'b0;
        out_valid_nxt             = 1'b1;
        out_word_nxt.served_track = emit_trk16;
        out_word_nxt.seek_sum     = add_res;
        out_word_nxt.last_served  = (n_r == CNT_W'(1));
        if (n_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt   = CNT_W'(1);
          scan_go = 1'b1;
          scan_k  = CNT_W'(1);
        end
      end
      S_SCAN: begin
        pv_nxt = 1'b1;
        if (rd_idx_r == end_idx_r) begin
          state_nxt = S_WAIT;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (found_r) begin
          mem_we   = 1'b1;
          head_nxt = best_trk_r;
          if ((mode_r == MODE_CSCAN) && wrap_r) begin
            total_nxt = sub_res;
            wrap_nxt  = 1'b0;
          end else begin
            add_base  = total_r;
            add_opnd  = best_d_r;
            total_nxt = add_res;
          end
          out_valid_nxt             = 1'b1;
          out_word_nxt.served_track = emit_trk16;
          out_word_nxt.seek_sum     = total_nxt;
          out_word_nxt.last_served  = (k_inc == n_r);
          k_nxt                     = k_inc;
          if (k_inc == n_r) begin
            state_nxt = S_IDLE;
          end else begin
            scan_go = 1'b1;
            scan_k  = k_inc;
          end
        end else begin
          if (mode_r == MODE_SCAN) begin
            dir_nxt = !dir_r;
          end else begin
            // wrap to track 0, charging the climb back down
            add_base  = total_r;
            add_opnd  = head_r;
            total_nxt = add_res;
            head_nxt  = '0;
            wrap_nxt  = 1'b1;
          end
          scan_go = 1'b1;
          scan_k  = k_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (scan_go) begin
      state_nxt = S_SCAN;
      found_nxt = 1'b0;
      if (mode_r == MODE_FIFO) begin
        rd_idx_nxt  = scan_k[IDX_W-1:0];
        end_idx_nxt = scan_k[IDX_W-1:0];
      end else begin
        rd_idx_nxt  = IDX_W'(1);
        end_idx_nxt = n_m1[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      total_r     <= '0;
      dir_r       <= 1'b0;
      wrap_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      dir_r       <= dir_nxt;
      wrap_r      <= wrap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    mode_r     <= mode_nxt;
    rd_idx_r   <= rd_idx_nxt;
    end_idx_r  <= end_idx_nxt;
    pidx_r     <= pidx_nxt;
    best_idx_r <= best_idx_nxt;
    best_trk_r <= best_trk_nxt;
    best_d_r   <= best_d_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== design/dss_ram.sv =====
module dss_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/dss_cfg_regs.sv =====
module dss_cfg_regs
  import dss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        CFG_IDX_POLICY: cfg_nxt.policy_mode = pwdata[1:0];
        CFG_IDX_DIR:    cfg_nxt.initial_direction = pwdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy_mode       <= MODE_FIFO;
      cfg_r.initial_direction <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_IDX_POLICY: prdata = {{(CFG_DATA_W-2){1'b0}}, cfg_r.policy_mode};
      CFG_IDX_DIR:    prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.initial_direction};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

// ===== design/dss_checker.sv =====
module dss_checker
  import dss_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // a closing word always launches a schedule
  a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.last_request) |=> busy)
    else $error("closing word did not start a schedule");

  // results come only out of scheduling work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a running schedule");

  // more tracks pending keeps the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last_served) |-> busy)
    else $error("schedule stopped before its final track");

  // a new schedule cannot emit right after the final track
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_served) |=> !out_valid)
    else $error("result directly after the final track");

endmodule

bind disk_seek_scheduler_unit dss_checker u_dss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);
